// ----- hw/rtl/buddy_page_allocator_assert.svh -----
// Assertion macros for the buddy page allocator.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");

`endif

// ----- hw/rtl/bpa_pkg.sv -----
// Shared constants for the buddy page allocator.
// No dependencies.
package bpa_pkg;
  localparam int unsigned POOL_PAGES = 1024;
  localparam int unsigned NODE_COUNT = 2 * POOL_PAGES - 1;
  localparam int unsigned IDX_W      = $clog2(NODE_COUNT);
  localparam int unsigned CAP_W      = $clog2(POOL_PAGES) + 1;
  localparam int unsigned OFF_W      = $clog2(POOL_PAGES);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_BAD_OFF   = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;
endpackage

// ----- hw/rtl/buddy_page_allocator.sv -----
// Channel  | dir | tdata / tuser
// in       | in  | tdata: request_pages[10:0], block_offset[20:11]; tuser: func
// out      | out | tdata: status[1:0], granted_offset[11:2], block_pages[22:12],
//          |     |        free_count[33:23]
// Walk: an allocation reads one node per level down, then reads the sibling and writes the
// parent per level up; a free climbs from the leaf, then merges upward the same way.
// Node memory: one read and one write per cycle, with registered read data.
// After reset a clearing pass loads every node before in_tready rises.
// A result waits in the output register; the next transfer is taken meanwhile.
// Top level of the buddy page allocator: node memory plus walk sequencer.
// Depends on bpa_pkg and buddy_page_allocator_assert.svh.
module buddy_page_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // request_pages[10:0], block_offset[20:11]
  input  logic [0:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status, granted_offset, block_pages, free_count
);
  import bpa_pkg::*;
  `include "buddy_page_allocator_assert.svh"

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_ROOT, S_A_DESC, S_F_CLIMB, S_UP_RD, S_UP_WR, S_DONE
  } state_t;

  state_t            state_r;
  logic [CAP_W-1:0]  mem [NODE_COUNT];
  logic [CAP_W-1:0]  rd_data_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_en;
  logic              we;
  logic [IDX_W-1:0]  wa;
  logic [CAP_W-1:0]  wd;

  logic [IDX_W-1:0]  idx_r, clr_idx_r;
  logic [CAP_W-1:0]  clr_sz_r;
  logic [CAP_W-1:0]  nsz_r, size_r, cv_r, free_r, pages_r;
  logic [OFF_W-1:0]  off_r, in_off_r;
  logic [1:0]        st_r;
  logic              fn_r;
  logic              out_valid_r;
  logic [39:0]       out_data_r;

  logic [CAP_W-1:0]  req, want, ceil_sz;
  logic [OFF_W-1:0]  req_off;
  logic [IDX_W-1:0]  parent, sibling, lchild, desc_idx, leaf_idx;
  logic [CAP_W-1:0]  half, up_sz, merged;
  logic [CAP_W:0]    pair_sum;
  logic              go_left, first_node;

  assign req     = in_tdata[10:0];
  assign req_off = in_tdata[20:11];
  assign want    = (req == '0) ? CAP_W'(1) : req;

  always_comb begin
    ceil_sz = '0;
    for (int k = CAP_W - 1; k >= 0; k--) begin
      if ((CAP_W'(1) << k) >= want) ceil_sz = CAP_W'(1) << k;
    end
  end

  assign parent   = (idx_r - IDX_W'(1)) >> 1;
  assign sibling  = idx_r[0] ? idx_r + IDX_W'(1) : idx_r - IDX_W'(1);
  assign half     = nsz_r >> 1;
  assign go_left  = rd_data_r >= size_r;
  assign desc_idx = go_left ? {idx_r[IDX_W-2:0], 1'b1} : ({idx_r[IDX_W-2:0], 1'b0} + IDX_W'(2));
  assign lchild   = {desc_idx[IDX_W-2:0], 1'b1};
  assign leaf_idx = IDX_W'(req_off) + IDX_W'(POOL_PAGES - 1);
  assign up_sz    = nsz_r << 1;
  assign pair_sum = {1'b0, cv_r} + {1'b0, rd_data_r};
  assign merged   = (fn_r == FN_FREE && pair_sum == {1'b0, up_sz}) ? up_sz :
                    ((cv_r > rd_data_r) ? cv_r : rd_data_r);
  assign first_node = ((clr_idx_r + IDX_W'(1)) & clr_idx_r) == '0 && clr_idx_r != '0;

  // node memory
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    we      = 1'b0;
    wa      = idx_r;
    wd      = '0;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_idx_r;
        wd = first_node ? clr_sz_r >> 1 : clr_sz_r;
      end
      S_IDLE: begin
        rd_en   = 1'b1;
        rd_addr = (in_tuser[0] == FN_FREE) ? leaf_idx : '0;
      end
      S_A_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(1);
        if (rd_data_r >= size_r && nsz_r == size_r) begin
          we = 1'b1;
          wa = '0;
        end
      end
      S_A_DESC: begin
        if (half == size_r) begin
          we = 1'b1;
          wa = desc_idx;
        end else begin
          rd_en   = 1'b1;
          rd_addr = lchild;
        end
      end
      S_F_CLIMB: begin
        if (rd_data_r == '0) begin
          we = 1'b1;
          wd = nsz_r;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
        end
      end
      S_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = sibling;
      end
      S_UP_WR: begin
        we = 1'b1;
        wa = parent;
        wd = merged;
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      clr_sz_r    <= CAP_W'(POOL_PAGES);
      free_r      <= CAP_W'(POOL_PAGES);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          if (first_node) clr_sz_r <= clr_sz_r >> 1;
          clr_idx_r <= clr_idx_r + IDX_W'(1);
          if (clr_idx_r == IDX_W'(NODE_COUNT - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            fn_r     <= in_tuser[0];
            in_off_r <= req_off;
            off_r    <= '0;
            pages_r  <= '0;
            if (in_tuser[0] == FN_FREE) begin
              if ({1'b0, req_off} >= (OFF_W + 1)'(POOL_PAGES)) begin
                st_r    <= ST_BAD_OFF;
                state_r <= S_DONE;
              end else begin
                idx_r   <= leaf_idx;
                nsz_r   <= CAP_W'(1);
                state_r <= S_F_CLIMB;
              end
            end else if (want > free_r) begin
              st_r    <= ST_NO_SPACE;
              state_r <= S_DONE;
            end else begin
              size_r  <= ceil_sz;
              nsz_r   <= CAP_W'(POOL_PAGES);
              idx_r   <= '0;
              state_r <= S_A_ROOT;
            end
          end
        end
        S_A_ROOT: begin
          if (rd_data_r < size_r) begin
            st_r    <= ST_NO_SPACE;
            state_r <= S_DONE;
          end else if (nsz_r == size_r) begin
            cv_r    <= '0;
            free_r  <= free_r - size_r;
            st_r    <= ST_OK;
            pages_r <= size_r;
            state_r <= S_DONE;
          end else begin
            state_r <= S_A_DESC;
          end
        end
        S_A_DESC: begin
          idx_r <= desc_idx;
          nsz_r <= half;
          if (!go_left) off_r <= off_r + OFF_W'(half);
          if (half == size_r) begin
            cv_r    <= '0;
            free_r  <= free_r - size_r;
            st_r    <= ST_OK;
            pages_r <= size_r;
            state_r <= S_UP_RD;
          end
        end
        S_F_CLIMB: begin
          if (rd_data_r == '0) begin
            cv_r    <= nsz_r;
            free_r  <= free_r + nsz_r;
            pages_r <= nsz_r;
            off_r   <= in_off_r & ~OFF_W'(nsz_r - CAP_W'(1));
            st_r    <= ST_OK;
            state_r <= (idx_r == '0) ? S_DONE : S_UP_RD;
          end else if (idx_r == '0) begin
            st_r    <= ST_NOT_ALLOC;
            state_r <= S_DONE;
          end else begin
            idx_r <= parent;
            nsz_r <= up_sz;
          end
        end
        S_UP_RD: state_r <= S_UP_WR;
        S_UP_WR: begin
          cv_r    <= merged;
          idx_r   <= parent;
          nsz_r   <= up_sz;
          state_r <= (parent == '0) ? S_DONE : S_UP_RD;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {6'd0, free_r, pages_r, off_r, st_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BPA_ASSERT_IMPL(a_free_bound, 1'b1, free_r <= CAP_W'(POOL_PAGES))
  `BPA_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, state_r != S_IDLE)
  `BPA_ASSERT_IMPL(a_no_out_in_clear, state_r == S_CLEAR, !out_valid_r)
endmodule

// ----- tb/sv/tb_buddy_page_allocator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for buddy_page_allocator: directed table plus random alloc/free mix.
// Depends on bpa_pkg and the buddy_page_allocator RTL.
module tb_buddy_page_allocator;
  import bpa_pkg::*;

  typedef struct packed {
    logic [10:0] free_cnt;
    logic [10:0] pages;
    logic [9:0]  offset;
    logic [1:0]  status;
  } alloc_result_t;

  typedef struct {
    logic        fn;
    logic [10:0] req;
    logic [9:0]  offs;
    logic        has_exp;
    logic [1:0]  st;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;

  buddy_page_allocator dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [10:0] cap_tree [0:NODE_COUNT-1];
  logic [10:0] pages_free;
  alloc_result_t result_q [$];
  int fails = 0;
  int send_idle_pct = 32;
  int recv_idle_pct = 63;
  int idle_cnt = 0;
  int live_offs [$];

  function automatic alloc_result_t predict_alloc(input logic [10:0] req);
    alloc_result_t r;
    int want, size, idx, nsz, off;
    r = '0;
    want = (req == 0) ? 1 : req;
    size = 1;
    if (want > pages_free) begin
      r.status = ST_NO_SPACE;
    end else begin
      while (size < want) size *= 2;
      if (cap_tree[0] < size) begin
        r.status = ST_NO_SPACE;
      end else begin
        idx = 0;
        for (nsz = POOL_PAGES; nsz > size; nsz /= 2)
          idx = (cap_tree[2*idx+1] >= size) ? 2*idx+1 : 2*idx+2;
        cap_tree[idx] = '0;
        off = (idx + 1) * nsz - POOL_PAGES;
        while (idx != 0) begin
          idx = (idx + 1) / 2 - 1;
          cap_tree[idx] = (cap_tree[2*idx+1] > cap_tree[2*idx+2]) ?
                          cap_tree[2*idx+1] : cap_tree[2*idx+2];
        end
        pages_free = 11'(pages_free - size);
        r.status = ST_OK;
        r.offset = 10'(off);
        r.pages = 11'(size);
      end
    end
    r.free_cnt = pages_free;
    return r;
  endfunction

  function automatic alloc_result_t predict_free(input logic [9:0] offs);
    alloc_result_t r;
    int idx, nsz, freed, lsum;
    r = '0;
    idx = offs + POOL_PAGES - 1;
    nsz = 1;
    while (cap_tree[idx] != 0 && idx != 0) begin
      nsz *= 2;
      idx = (idx + 1) / 2 - 1;
    end
    if (cap_tree[idx] != 0) begin
      r.status = ST_NOT_ALLOC;
    end else begin
      cap_tree[idx] = 11'(nsz);
      r.offset = 10'((idx + 1) * nsz - POOL_PAGES);
      pages_free = 11'(pages_free + nsz);
      freed = nsz;
      while (idx != 0) begin
        idx = (idx + 1) / 2 - 1;
        nsz *= 2;
        lsum = cap_tree[2*idx+1] + cap_tree[2*idx+2];
        if (lsum == nsz) cap_tree[idx] = 11'(nsz);
        else cap_tree[idx] = (cap_tree[2*idx+1] > cap_tree[2*idx+2]) ?
                             cap_tree[2*idx+1] : cap_tree[2*idx+2];
      end
      r.status = ST_OK;
      r.pages = 11'(freed);
    end
    r.free_cnt = pages_free;
    return r;
  endfunction

  // tvalid stays high into the next item unless the sender idles
  task automatic send_op(input logic fn, input logic [10:0] req, input logic [9:0] offs,
                         input logic has_exp, input logic [1:0] st);
    alloc_result_t r;
    while (($urandom_range(99) < send_idle_pct)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= {3'b000, offs, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = (fn == FN_ALLOC) ? predict_alloc(req) : predict_free(offs);
    if (has_exp && r.status != st) begin
      $error("table status: expected %0d predicted %0d", st, r.status);
      fails++;
    end
    if (r.status == ST_OK) begin
      if (fn == FN_ALLOC) live_offs.push_back(r.offset);
    end
    result_q.push_back(r);
  endtask

  // receiver and checker
  always @(posedge clk) begin
    alloc_result_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[33:0];
        idle_cnt <= 0;
        if (result_q.size() == 0) begin
          $error("unexpected result transfer: %h", out_tdata);
          fails++;
        end else begin
          want = result_q.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d actual %0d", want.status, got.status); fails++;
          end
          if (got.offset != want.offset) begin
            $error("granted_offset: expected %0d actual %0d", want.offset, got.offset);
            fails++;
          end
          if (got.pages != want.pages) begin
            $error("block_pages: expected %0d actual %0d", want.pages, got.pages); fails++;
          end
          if (got.free_cnt != want.free_cnt) begin
            $error("free_count: expected %0d actual %0d", want.free_cnt, got.free_cnt);
            fails++;
          end
        end
      end else if (in_tvalid && in_tready) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog; allows for the clearing pass and long stalls
  always @(posedge clk) begin
    if (idle_cnt > 20000) begin
      $display("** buddy_page_allocator: FAILED **");
      $finish;
    end
  end

  op_row_t dir_tab [] = '{
    '{FN_FREE,  11'd0,    10'd0,    1'b1, ST_NOT_ALLOC},
    '{FN_ALLOC, 11'd0,    10'd0,    1'b1, ST_OK},
    '{FN_ALLOC, 11'd1,    10'd1023, 1'b1, ST_OK},
    '{FN_ALLOC, 11'd3,    10'd0,    1'b1, ST_OK},
    '{FN_ALLOC, 11'd1024, 10'd0,    1'b1, ST_NO_SPACE},
    '{FN_ALLOC, 11'd2047, 10'd0,    1'b1, ST_NO_SPACE},
    '{FN_ALLOC, 11'd1000, 10'd0,    1'b1, ST_NO_SPACE},
    '{FN_ALLOC, 11'd512,  10'd0,    1'b1, ST_OK},
    '{FN_FREE,  11'd2047, 10'd5,    1'b1, ST_OK},
    '{FN_FREE,  11'd0,    10'd1023, 1'b1, ST_OK},
    '{FN_FREE,  11'd0,    10'd600,  1'b1, ST_NOT_ALLOC},
    '{FN_ALLOC, 11'd513,  10'd0,    1'b0, ST_OK},
    '{FN_FREE,  11'd0,    10'd0,    1'b0, ST_OK},
    '{FN_FREE,  11'd0,    10'd1,    1'b0, ST_OK},
    '{FN_ALLOC, 11'd1024, 10'd0,    1'b0, ST_OK},
    '{FN_FREE,  11'd0,    10'd700,  1'b1, ST_OK},
    '{FN_FREE,  11'd0,    10'd700,  1'b1, ST_NOT_ALLOC}
  };

  initial begin
    int phase, n, pick;
    logic [10:0] req;
    int sz;
    sz = 2 * POOL_PAGES;
    for (int i = 0; i < NODE_COUNT; i++) begin
      if (((i + 1) & i) == 0) sz /= 2;
      cap_tree[i] = 11'(sz);
    end
    pages_free = 11'(POOL_PAGES);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_tab[i])
      send_op(dir_tab[i].fn, dir_tab[i].req, dir_tab[i].offs, dir_tab[i].has_exp,
              dir_tab[i].st);
    live_offs.delete();
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 63 : 0;
      recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 32 : 0;
      for (n = 0; n < 400; n++) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          // mostly small requests, a few large ones
          req = ($urandom_range(9) == 0) ? 11'($urandom_range(2047)) : 11'($urandom_range(64));
          send_op(FN_ALLOC, req, 10'($urandom), 1'b0, ST_OK);
        end else if (pick < 85 && live_offs.size() > 0) begin
          sz = $urandom_range(live_offs.size() - 1);
          send_op(FN_FREE, 11'($urandom), 10'(live_offs[sz] + $urandom_range(1)), 1'b0,
                  ST_OK);
          live_offs.delete(sz);
        end else begin
          send_op(FN_FREE, 11'($urandom), 10'($urandom), 1'b0, ST_OK);
        end
      end
    end
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) $display("** buddy_page_allocator: PASSED **");
    else $display("** buddy_page_allocator: FAILED **");
    $finish;
  end
endmodule

// ----- buddy_page_allocator.f -----
+incdir+hw/rtl
hw/rtl/bpa_pkg.sv
hw/rtl/buddy_page_allocator.sv
tb/sv/tb_buddy_page_allocator.sv
